@@ rtl/core/hpa_pkg.sv @@
// ----------------------------------------------------------------------------
// hpa_pkg
// shared constants for the binary16 adder
// ----------------------------------------------------------------------------
`default_nettype none

package hpa_pkg;

    localparam int unsigned WordW  = 16;
    localparam int unsigned ExpW   = 5;
    localparam int unsigned FracW  = 10;
    localparam int unsigned SigW   = FracW + 1;
    localparam int unsigned Extra  = 3;
    localparam int unsigned WorkW  = SigW + Extra;
    localparam int unsigned ExpExtW = ExpW + 2;

    localparam logic [WordW-1:0] DefaultNan = 16'h7E00;
    localparam logic [ExpW-1:0]  ExpMax     = 5'h1F;

endpackage

`default_nettype wire

@@ rtl/core/half_precision_adder.sv @@
// ----------------------------------------------------------------------------
// half_precision_adder
// binary16 adder, round to nearest even, one registered pass per transaction
// ----------------------------------------------------------------------------
// channel   ports                        handshake
// input     operand_a, operand_b         start && !busy
// result    sum_bits                     done strobe, one cycle
//
// inputs are registered on accept, the sum is computed combinationally and
// registered into sum_bits; done follows start through in_valid_reg and out_valid_reg.
// busy is always low: a new transaction can start every cycle.
// rst_n clears the valid pipeline only; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module half_precision_adder (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [hpa_pkg::WordW-1:0] operand_a,
    input  wire logic [hpa_pkg::WordW-1:0] operand_b,
    output logic                           done,
    output logic [hpa_pkg::WordW-1:0]      sum_bits
);
    import hpa_pkg::*;

    logic             in_valid_reg;
    logic [WordW-1:0] a_reg;
    logic [WordW-1:0] b_reg;
    logic             out_valid_reg;
    logic [WordW-1:0] sum_reg;
    logic [WordW-1:0] sum_next;

    assign busy     = 1'b0;
    assign done     = out_valid_reg;
    assign sum_bits = sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= operand_a;
            b_reg <= operand_b;
        end
        if (in_valid_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    function automatic logic [4:0] lzc14(input logic [WorkW-1:0] v);
        logic [4:0] n;
        logic       hit;
        n   = 5'd0;
        hit = 1'b0;
        for (int i = WorkW - 1; i >= 0; i--)
        begin
            if (!hit && v[i])
            begin
                hit = 1'b1;
            end
            else if (!hit)
            begin
                n = n + 5'd1;
            end
        end
        return n;
    endfunction

    logic             a_nan, b_nan, a_inf, b_inf, swap, sub;
    logic [WordW-1:0] big, lesser;
    logic             sbig;
    logic [ExpW-1:0]  eb, es;
    logic [ExpW-1:0]  d;
    logic [WorkW-1:0] mb, ms, ms_al;
    logic [WorkW:0]   r_add;
    logic [WorkW-1:0] r_sub, r;
    logic [ExpExtW-1:0] e1;
    logic [4:0]       lz, sh;
    logic [SigW:0]    mant;
    logic             g, rest;
    logic [ExpExtW-1:0] e2;
    logic [WorkW-1:0] lost_mask;

    always_comb
    begin
        a_nan = (a_reg[14:10] == ExpMax) && (a_reg[9:0] != '0);
        b_nan = (b_reg[14:10] == ExpMax) && (b_reg[9:0] != '0);
        a_inf = (a_reg[14:0] == {ExpMax, 10'd0});
        b_inf = (b_reg[14:0] == {ExpMax, 10'd0});
        swap  = a_reg[14:0] < b_reg[14:0];
        big   = swap ? b_reg : a_reg;
        lesser = swap ? a_reg : b_reg;
        sbig  = big[15];
        sub   = a_reg[15] ^ b_reg[15];
        mb    = {(big[14:10] != '0), big[9:0], 3'b000};
        ms    = {(lesser[14:10] != '0), lesser[9:0], 3'b000};
        eb    = (big[14:10] == '0) ? 5'd1 : big[14:10];
        es    = (lesser[14:10] == '0) ? 5'd1 : lesser[14:10];
        d     = eb - es;
        lost_mask = '0;
        if (d > 5'd13)
        begin
            ms_al = {13'd0, (ms != '0)};
        end
        else
        begin
            lost_mask = ~({WorkW{1'b1}} << d[3:0]);
            ms_al = (ms >> d[3:0]) | {13'd0, ((ms & lost_mask) != '0)};
        end
        r_add = {1'b0, mb} + {1'b0, ms_al};
        r_sub = mb - ms_al;
        e1    = {2'b00, eb};
        lz    = lzc14(r_sub);
        sh    = 5'd0;
        if (!sub)
        begin
            if (r_add[WorkW])
            begin
                r  = r_add[WorkW:1] | {13'd0, r_add[0]};
                e1 = e1 + 7'd1;
            end
            else
            begin
                r = r_add[WorkW-1:0];
            end
        end
        else
        begin
            sh = ({2'b00, lz} < {2'b00, eb} - 7'd1) ? lz : 5'(eb - 5'd1);
            r  = r_sub << sh[3:0];
            e1 = e1 - {2'b00, sh};
        end
        mant = {1'b0, r[WorkW-1:Extra]};
        g    = r[2];
        rest = r[1] | r[0];
        if (g && (rest || mant[0]))
        begin
            mant = mant + 12'd1;
        end
        e2 = e1;
        if (mant[SigW])
        begin
            mant = mant >> 1;
            e2   = e2 + 7'd1;
        end
        if (!mant[FracW])
        begin
            e2 = '0;
        end

        if (a_nan)
        begin
            sum_next = a_reg | 16'h0200;
        end
        else if (b_nan)
        begin
            sum_next = b_reg | 16'h0200;
        end
        else if (a_inf && b_inf)
        begin
            sum_next = sub ? DefaultNan : a_reg;
        end
        else if (a_inf)
        begin
            sum_next = a_reg;
        end
        else if (b_inf)
        begin
            sum_next = b_reg;
        end
        else if (sub && r_sub == '0)
        begin
            sum_next = '0;
        end
        else if (r == '0)
        begin
            sum_next = {sbig, 15'd0};
        end
        else if (e2 >= 7'd31)
        begin
            sum_next = {sbig, ExpMax, 10'd0};
        end
        else
        begin
            sum_next = {sbig, e2[ExpW-1:0], mant[FracW-1:0]};
        end
    end

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> ##1 done) else $error("missing done");
    a_nodone: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(start) |=> !done) else $error("spurious done");
    a_nan_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && a_nan |=> sum_reg[14:9] == 6'h3F) else $error("nan lost");

endmodule

`default_nettype wire
